/* sv/tpfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfe_pkg
// Types, constants and helpers for the tabulated pair force engine.
// ----------------------------------------------------------------------------
package tpfe_pkg;

    localparam int ATOM_W    = 12;
    localparam int N_ATOMS   = 4096;
    localparam int TAB_W     = 15;
    localparam int TAB_DEPTH = 32768;
    localparam int ACC_W     = 48;

    // opcodes
    localparam logic [2:0] OP_LOAD_POS  = 3'd0;
    localparam logic [2:0] OP_LOAD_TAB  = 3'd1;
    localparam logic [2:0] OP_BOND      = 3'd2;
    localparam logic [2:0] OP_READ_FRC  = 3'd3;
    localparam logic [2:0] OP_READ_ENG  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_INV_BIN   = 2'd0;
    localparam logic [1:0] REG_TYPE_CNT  = 2'd1;
    localparam logic [1:0] REG_BIN_CNT   = 2'd2;

    localparam logic signed [50:0] SAT_MAX = 51'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [50:0] SAT_MIN = -51'sh0_8000_0000_0000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [11:0]        atom_a;
        logic [11:0]        atom_b;
        logic [3:0]         type_a;
        logic [3:0]         type_b;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [14:0]        table_index;
        logic signed [31:0] energy_entry;
        logic signed [31:0] slope_entry;
    } t_in_word;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic signed [47:0] energy_total;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_POS_A, ST_POS_B, ST_SQ, ST_SQRT, ST_BIN, ST_PAIR,
        ST_ADDR, ST_TAB, ST_DIV, ST_SCALE, ST_MUL, ST_FA_RD, ST_FA_WR, ST_FB_RD,
        ST_FB_WR, ST_RD_FRC, ST_RD_ENG
    } t_state;

    // clamp a wide sum into the 48-bit accumulator range
    function automatic logic signed [47:0] sat48(input logic signed [50:0] s);
        logic signed [47:0] r;
        if (s > SAT_MAX) r = SAT_MAX[47:0];
        else if (s < SAT_MIN) r = SAT_MIN[47:0];
        else r = s[47:0];
        return r;
    endfunction

    // magnitude of a 33-bit signed value
    function automatic logic [32:0] mag33(input logic signed [32:0] d);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

endpackage

/* sv/tabulated_pair_force_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabulated_pair_force_engine
// Pair force kernel with tabulated energy and slope, per-atom force
// accumulators in a synchronous memory and an energy total register.
// ----------------------------------------------------------------------------
// After reset the block clears the force memory, one entry a cycle, and
// stalls its input meanwhile. Position and table loads are written as they
// are accepted. A read waits for the output register; a force read clears
// the entry and an energy read clears the total. A bond does two position
// reads, three squares on one multiplier, a bit-serial square root, bin and
// address steps with a table read, a restoring division for slope/r, three
// force products and a read-modify-write of each atom's force entry on the
// single force memory port. One item is worked on at a time.
module tabulated_pair_force_engine
    import tpfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state r_state, n_state;

    logic [31:0] r_inv_bin;
    logic [4:0]  r_type_cnt;
    logic [7:0]  r_bin_cnt;

    // memories
    logic [95:0]  mem_pos [N_ATOMS];
    logic [63:0]  mem_tab [TAB_DEPTH];
    logic [143:0] mem_frc [N_ATOMS];
    logic [95:0]  r_pos_q;
    logic [63:0]  r_tab_q;
    logic [143:0] r_frc_q;

    // work registers
    logic [11:0]        r_a, r_b;
    logic [3:0]         r_ta, r_tb;
    logic [95:0]        r_pa;
    logic signed [32:0] r_d [3];
    logic [5:0]         r_cnt;
    logic [11:0]        r_clr;
    logic [63:0]        r_r2;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [63:0]        r_binprod;
    logic [7:0]         r_bin;
    logic signed [10:0] r_pair;
    logic [47:0]        r_dvd;
    logic               r_qneg;
    logic [31:0]        r_qmag;
    logic signed [49:0] r_ft [3];
    logic signed [47:0] r_energy;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic in_acc, out_free;
    logic pos_re, tab_re, frc_re, frc_we;
    logic [11:0]  pos_ra, frc_ra, frc_wa;
    logic [14:0]  tab_ra;
    logic [143:0] frc_wd;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign pready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_bin  <= 32'd655360;
            r_type_cnt <= 5'd16;
            r_bin_cnt  <= 8'd128;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_INV_BIN:  r_inv_bin  <= pwdata;
                REG_TYPE_CNT: r_type_cnt <= pwdata[4:0];
                REG_BIN_CNT:  r_bin_cnt  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_INV_BIN:  prdata = r_inv_bin;
            REG_TYPE_CNT: prdata = {27'd0, r_type_cnt};
            REG_BIN_CNT:  prdata = {24'd0, r_bin_cnt};
            default:      prdata = 32'd0;
        endcase
    end

    // shared datapath pieces
    logic [1:0]   sel;
    logic [32:0]  dmag;
    logic [65:0]  sq_prod, sq_sum;
    logic [64:0]  fm_prod;
    logic [48:0]  fm_mag;
    logic [35:0]  sr_sh, sr_trial;
    logic [32:0]  dv_sh;
    logic [31:0]  bin_hi;
    logic [3:0]   mn, mx;
    logic [8:0]   mn_t;
    logic [7:0]   tri_n;
    logic [17:0]  addr_w;
    logic signed [31:0] slope, engy;
    logic [31:0]  slope_mag;
    logic signed [47:0] fx_q, fy_q, fz_q;

    assign sel     = r_cnt[1:0];
    assign dmag    = mag33(r_d[sel]);
    assign sq_prod = 66'(dmag) * 66'(dmag);
    assign sq_sum  = {2'd0, r_r2} + sq_prod;
    assign fm_prod = 65'(dmag) * 65'(r_qmag);
    assign fm_mag  = fm_prod[64:16];
    assign sr_sh   = {r_rem, r_r2[63:62]};
    assign sr_trial = {2'd0, r_root, 2'b01};
    assign dv_sh   = {r_rem[31:0], r_dvd[47]};
    assign bin_hi  = r_binprod[63:32];
    assign mn      = (r_ta < r_tb) ? r_ta : r_tb;
    assign mx      = (r_ta < r_tb) ? r_tb : r_ta;
    assign mn_t    = 9'(mn) * 9'(r_type_cnt);
    assign tri_n   = 8'((8'(mn) * (8'(mn) + 8'd1)) >> 1);
    assign addr_w  = 18'(r_pair[8:0]) * 18'(r_bin_cnt) + 18'(r_bin);
    assign engy    = r_tab_q[63:32];
    assign slope   = r_tab_q[31:0];
    assign slope_mag = slope[31] ? 32'(-slope) : 32'(slope);
    assign fx_q    = r_frc_q[143:96];
    assign fy_q    = r_frc_q[95:48];
    assign fz_q    = r_frc_q[47:0];

    // next state and memory strobes
    always_comb begin
        n_state = r_state;
        pos_re = 1'b0; pos_ra = r_a;
        tab_re = 1'b0; tab_ra = addr_w[14:0];
        frc_re = 1'b0; frc_ra = r_a;
        frc_we = 1'b0; frc_wa = r_a; frc_wd = '0;
        case (r_state)
            ST_CLEAR: begin
                frc_we = 1'b1;
                frc_wa = r_clr;
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.opcode)
                        OP_BOND: begin
                            pos_re = 1'b1;
                            pos_ra = i_in_word.atom_a;
                            n_state = ST_POS_A;
                        end
                        OP_READ_FRC: begin
                            frc_re = 1'b1;
                            frc_ra = i_in_word.atom_a;
                            n_state = ST_RD_FRC;
                        end
                        OP_READ_ENG: n_state = ST_RD_ENG;
                        default: ;
                    endcase
                end
            end
            ST_POS_A: begin
                pos_re = 1'b1;
                pos_ra = r_b;
                n_state = ST_POS_B;
            end
            ST_POS_B: n_state = ST_SQ;
            ST_SQ:    if (r_cnt == 6'd2) n_state = ST_SQRT;
            ST_SQRT:  if (r_cnt == 6'd31) n_state = ST_BIN;
            ST_BIN:   n_state = ST_PAIR;
            ST_PAIR: begin
                if (bin_hi >= 32'(r_bin_cnt)) n_state = ST_IDLE;
                else n_state = ST_ADDR;
            end
            ST_ADDR: begin
                if (r_pair < 0 || addr_w >= 18'(TAB_DEPTH)) begin
                    n_state = ST_IDLE;
                end else begin
                    tab_re = 1'b1;
                    n_state = ST_TAB;
                end
            end
            ST_TAB:   n_state = (r_root == '0) ? ST_IDLE : ST_DIV;
            ST_DIV:   if (r_cnt == 6'd47) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_MUL;
            ST_MUL:   if (r_cnt == 6'd2) n_state = ST_FA_RD;
            ST_FA_RD: begin
                frc_re = 1'b1;
                n_state = ST_FA_WR;
            end
            ST_FA_WR: begin
                frc_we = 1'b1;
                frc_wd = {sat48(51'(fx_q) - 51'(r_ft[0])),
                          sat48(51'(fy_q) - 51'(r_ft[1])),
                          sat48(51'(fz_q) - 51'(r_ft[2]))};
                n_state = ST_FB_RD;
            end
            ST_FB_RD: begin
                frc_re = 1'b1;
                frc_ra = r_b;
                n_state = ST_FB_WR;
            end
            ST_FB_WR: begin
                frc_we = 1'b1;
                frc_wa = r_b;
                frc_wd = {sat48(51'(fx_q) + 51'(r_ft[0])),
                          sat48(51'(fy_q) + 51'(r_ft[1])),
                          sat48(51'(fz_q) + 51'(r_ft[2]))};
                n_state = ST_IDLE;
            end
            ST_RD_FRC: begin
                if (out_free) begin
                    frc_we = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RD_ENG: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else r_state <= n_state;
    end

    // position memory
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_word.opcode == OP_LOAD_POS)
            mem_pos[i_in_word.atom_a] <= {i_in_word.coord_x, i_in_word.coord_y,
                                          i_in_word.coord_z};
        if (pos_re) r_pos_q <= mem_pos[pos_ra];
    end

    // energy and slope table memory
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_word.opcode == OP_LOAD_TAB)
            mem_tab[i_in_word.table_index] <= {i_in_word.energy_entry,
                                               i_in_word.slope_entry};
        if (tab_re) r_tab_q <= mem_tab[tab_ra];
    end

    // force accumulator memory
    always_ff @(posedge i_clk) begin
        if (frc_we) mem_frc[frc_wa] <= frc_wd;
        if (frc_re) r_frc_q <= mem_frc[frc_ra];
    end

    // control counters, energy total and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_cnt       <= '0;
            r_energy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 12'd1;
            if (r_state != n_state) r_cnt <= '0;
            else r_cnt <= r_cnt + 6'd1;
            if (r_state == ST_TAB)
                r_energy <= sat48(51'(r_energy) + 51'(engy));
            if (r_state == ST_RD_FRC && out_free) begin
                r_out_valid <= 1'b1;
                r_out_word  <= '{force_x: fx_q, force_y: fy_q, force_z: fz_q,
                                 energy_total: '0};
            end
            if (r_state == ST_RD_ENG && out_free) begin
                r_out_valid <= 1'b1;
                r_out_word  <= '{force_x: '0, force_y: '0, force_z: '0,
                                 energy_total: r_energy};
                r_energy    <= '0;
            end
        end
    end

    // bond datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_a  <= i_in_word.atom_a;
                r_b  <= i_in_word.atom_b;
                r_ta <= i_in_word.type_a;
                r_tb <= i_in_word.type_b;
            end
            ST_POS_A: r_pa <= r_pos_q;
            ST_POS_B: begin
                r_d[0] <= 33'(signed'(r_pa[95:64])) - 33'(signed'(r_pos_q[95:64]));
                r_d[1] <= 33'(signed'(r_pa[63:32])) - 33'(signed'(r_pos_q[63:32]));
                r_d[2] <= 33'(signed'(r_pa[31:0]))  - 33'(signed'(r_pos_q[31:0]));
                r_r2   <= '0;
                r_rem  <= '0;
                r_root <= '0;
            end
            // sum of squares, saturating at all ones
            ST_SQ: r_r2 <= (sq_sum[65:64] != 2'd0) ? '1 : sq_sum[63:0];
            // one root bit per cycle
            ST_SQRT: begin
                if (sr_sh >= sr_trial) begin
                    r_rem  <= 34'(sr_sh - sr_trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= sr_sh[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_r2 <= {r_r2[61:0], 2'b00};
            end
            ST_BIN: r_binprod <= 64'(r_root) * 64'(r_inv_bin);
            ST_PAIR: begin
                r_bin  <= bin_hi[7:0];
                r_pair <= 11'(mn_t) - 11'(tri_n) + 11'(mx);
            end
            ST_TAB: begin
                r_qneg <= slope[31];
                r_dvd  <= {slope_mag, 16'd0};
                r_rem  <= '0;
            end
            // restoring divide, quotient shifts into the dividend register
            ST_DIV: begin
                if (dv_sh >= 33'(r_root)) begin
                    r_rem <= 34'(dv_sh - 33'(r_root));
                    r_dvd <= {r_dvd[46:0], 1'b1};
                end else begin
                    r_rem <= 34'(dv_sh);
                    r_dvd <= {r_dvd[46:0], 1'b0};
                end
            end
            ST_SCALE: begin
                if (r_qneg)
                    r_qmag <= (r_dvd > 48'h8000_0000) ? 32'h8000_0000 : r_dvd[31:0];
                else
                    r_qmag <= (r_dvd > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_dvd[31:0];
            end
            ST_MUL: begin
                if (r_d[sel][32] ^ r_qneg) r_ft[sel] <= -50'(fm_mag);
                else r_ft[sel] <= 50'(fm_mag);
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SQRT |-> r_rem <= {1'b0, r_root, 1'b0})
        else $error("square root remainder out of range");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < 34'(r_root))
        else $error("divider remainder not below divisor");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_root != '0)
        else $error("divide by zero distance");
    a_frc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frc_we |-> (r_state == ST_CLEAR || r_state == ST_FA_WR ||
                    r_state == ST_FB_WR || r_state == ST_RD_FRC))
        else $error("unexpected force memory write");
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out_word))
        else $error("pending result overwritten");
`endif

endmodule
